// File: src/dq_pkg.sv
// shared types, codes and defaults for the double-ended queue
package dq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int OCC_W = 5;

  // operation codes
  localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [1:0] FUNC_PUSH_REAR  = 2'd1;
  localparam logic [1:0] FUNC_POP_FRONT  = 2'd2;
  localparam logic [1:0] FUNC_POP_REAR   = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic [OCC_W-1:0]   occupancy;
    logic               now_empty;
  } dq_out_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic               shift_back;   // push at front: each cell takes its front neighbor
    logic               shift_fwd;    // pop at front: each cell takes its rear neighbor
    logic               load_rear;    // push at rear: the cell at the fill level loads
    logic signed [31:0] word;
  } dq_cell_ctrl_t;

endpackage

// File: src/double_ended_queue_core.sv
// top level of the double-ended queue built as a chain of storage cells
//
// Usage: present an operation on in_item and raise start; the transaction is
// taken at the rising edge where start is high and busy is low. busy stays
// low, so a new transaction may be issued every cycle.
// Operations: push front, push rear, pop front, pop rear. Words sit in a row
// of DEPTH cells with the front word in cell 0; a front push shifts the whole
// row one cell toward the rear, a front pop shifts it one cell forward, a
// rear push loads the cell at the fill level and a rear pop only lowers it.
// Each transaction yields exactly one result on out_item, marked by
// out_strobe for one cycle, in the cycle after the transaction is taken: the
// cell row and fill count update at that same edge, which sets the
// throughput at one transaction per cycle.
// A pop on an empty queue reports the empty status, a push on a full queue
// reports the full status and drops the word; state is unchanged in both.
// Reset (rst_n low, synchronous) empties the queue and clears the strobe;
// cell contents are left as they are and are never read before written.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module double_ended_queue_core #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  dq_pkg::dq_in_t  in_item,
  output logic            out_strobe,
  output dq_pkg::dq_out_t out_item
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic               out_strobe_r;
  dq_out_t            out_item_r;
  dq_out_t            out_item_nxt;
  dq_cell_ctrl_t      ctrl;
  logic signed [31:0] cell_data [DEPTH];
  logic               accept;
  logic               is_push;
  logic               full;
  logic               empty;
  logic [AW-1:0]      rear_idx;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_push = (in_item.func == FUNC_PUSH_FRONT) || (in_item.func == FUNC_PUSH_REAR);
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rear_idx = AW'(count_r - CW'(1));

  // decode the operation into cell controls, fill level and result
  always_comb begin
    ctrl.shift_back = 1'b0;
    ctrl.shift_fwd  = 1'b0;
    ctrl.load_rear  = 1'b0;
    ctrl.word       = in_item.push_value;
    count_nxt       = count_r;
    out_item_nxt.pop_value = '0;
    out_item_nxt.status    = ST_DONE;
    if (accept) begin
      if (is_push && full) begin
        out_item_nxt.status = ST_FULL;
      end else if (!is_push && empty) begin
        out_item_nxt.status = ST_EMPTY;
      end else begin
        unique case (in_item.func)
          FUNC_PUSH_FRONT: begin
            ctrl.shift_back = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          FUNC_PUSH_REAR: begin
            ctrl.load_rear = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          FUNC_POP_FRONT: begin
            ctrl.shift_fwd = 1'b1;
            out_item_nxt.pop_value = cell_data[0];
            count_nxt = count_r - CW'(1);
          end
          FUNC_POP_REAR: begin
            out_item_nxt.pop_value = cell_data[rear_idx];
            count_nxt = count_r - CW'(1);
          end
          default: begin
            count_nxt = count_r;
          end
        endcase
      end
    end
    out_item_nxt.occupancy = OCC_W'(count_nxt);
    out_item_nxt.now_empty = (count_nxt == '0);
  end

  // chain of cells, front word in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] front_src;
    logic signed [31:0] rear_src;
    if (i == 0) begin : g_first
      assign front_src = in_item.push_value;
    end else begin : g_mid
      assign front_src = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rear_src = cell_data[i];
    end else begin : g_inner
      assign rear_src = cell_data[i+1];
    end
    dq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .front_data (front_src),
      .rear_data  (rear_src),
      .data       (cell_data[i])
    );
  end

  // fill count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= accept;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // fill level never exceeds the cell count
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");

  // a result appears only for a transaction taken the cycle before
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept))
    else $error("result without transaction");

  // pop on empty queue reports empty and leaves the count at zero
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_push && empty) |=> (out_strobe && out_item.status == ST_EMPTY
      && count_r == '0))
    else $error("pop on empty queue mishandled");

  // push on full queue reports full and keeps the count
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_push && full) |=> (out_item.status == ST_FULL && count_r == CW'(DEPTH)))
    else $error("push on full queue mishandled");

endmodule

// File: src/dq_cell.sv
// one storage cell of the queue chain
module dq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                   clk,
  input  dq_pkg::dq_cell_ctrl_t  ctrl,
  input  logic [CW-1:0]          count,
  input  logic signed [31:0]     front_data,
  input  logic signed [31:0]     rear_data,
  output logic signed [31:0]     data
);
  import dq_pkg::*;

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  // pick the word this cell holds next cycle
  always_comb begin
    data_nxt = data_r;
    priority if (ctrl.shift_back) begin
      data_nxt = front_data;
    end else if (ctrl.shift_fwd) begin
      data_nxt = rear_data;
    end else if (ctrl.load_rear && (count == CW'(IDX))) begin
      data_nxt = ctrl.word;
    end else begin
      data_nxt = data_r;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
